>>> rtl/core/fccm_pkg.sv
package fccm_pkg;

  localparam int TABLE_ENTRIES_DEF      = 65536;
  localparam int FIRST_DATA_CLUSTER_DEF = 33;

  localparam int LINK_W  = 16;
  localparam int LIMIT_W = 17;
  localparam int COUNT_W = 17;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

  // entry markers
  localparam logic [LINK_W-1:0] MARK_FREE  = 16'd1;
  localparam logic [LINK_W-1:0] MARK_END   = 16'd2;
  localparam logic [LINK_W-1:0] MARK_TABLE = 16'd3;
  localparam logic [LINK_W-1:0] MARK_DIR   = 16'd4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_START = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [LINK_W-1:0]  cluster;
    logic [COUNT_W-1:0] free_clusters;
  } result_t;

  // formatted value of one table entry
  function automatic logic [LINK_W-1:0] layout_entry(input logic [LIMIT_W-1:0] idx,
                                                     input logic [LIMIT_W-1:0] first_data);
    logic [LIMIT_W-1:0] nxt;
    nxt = idx + 17'd1;
    if (nxt < first_data) begin
      return MARK_TABLE;
    end else if (nxt == first_data) begin
      return MARK_DIR;
    end
    return MARK_FREE;
  endfunction

endpackage

>>> rtl/core/fccm_table.sv
module fccm_table #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  logic [fccm_pkg::LINK_W-1:0]      wdata,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output logic [fccm_pkg::LINK_W-1:0]      rdata
);
  import fccm_pkg::*;

  logic [LINK_W-1:0] mem [TABLE_ENTRIES];

  // write-first: a read of the entry being written returns the new value
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fccm_seq.sv
module fccm_seq #(
  parameter int TABLE_ENTRIES      = fccm_pkg::TABLE_ENTRIES_DEF,
  parameter int FIRST_DATA_CLUSTER = fccm_pkg::FIRST_DATA_CLUSTER_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [fccm_pkg::LIMIT_W-1:0]      limit,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fccm_pkg::CMD_W-1:0]        command,
  input  logic [fccm_pkg::LINK_W-1:0]       start_cluster,
  output logic                              res_valid,
  input  logic                              res_ready,
  output fccm_pkg::result_t                 res,
  output logic                              mem_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  mem_waddr,
  output logic [fccm_pkg::LINK_W-1:0]       mem_wdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  mem_raddr,
  input  logic [fccm_pkg::LINK_W-1:0]       mem_rdata
);
  import fccm_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW:0]        LAST  = (AW+1)'(TABLE_ENTRIES - 1);
  localparam logic [AW:0]        STEPS_MAX = (AW+1)'(TABLE_ENTRIES);
  localparam logic [LIMIT_W-1:0] FDC   = LIMIT_W'(FIRST_DATA_CLUSTER);
  localparam logic [AW:0]        FDC_A = (AW+1)'(FIRST_DATA_CLUSTER);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_FORMAT   = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_WALK_RD  = 7'b0001000,
    ST_WALK_CHK = 7'b0010000,
    ST_WR_LINK  = 7'b0100000,
    ST_REPLY    = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic [CMD_W-1:0]    cmd, cmd_next;
  logic [AW:0]         addr, addr_next;
  logic [AW-1:0]       cur, cur_next;
  logic                pend, pend_next;
  logic [AW-1:0]       pidx, pidx_next;
  logic                first, first_next;
  logic [AW:0]         steps, steps_next;
  logic [COUNT_W-1:0]  cnt, cnt_next;
  logic                reply, reply_next;
  result_t             res_next;

  logic v_link, v_end, start_data, scan_issue;

  assign v_end      = (mem_rdata == MARK_END);
  assign v_link     = (mem_rdata > MARK_DIR) && ({1'b0, mem_rdata} >= FDC)
                      && ({1'b0, mem_rdata} < limit);
  assign start_data = ({1'b0, start_cluster} >= FDC) && ({1'b0, start_cluster} < limit);
  assign scan_issue = (LIMIT_W'(addr) < limit);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_REPLY);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    addr_next  = addr;
    cur_next   = cur;
    pend_next  = pend;
    pidx_next  = pidx;
    first_next = first;
    steps_next = steps;
    cnt_next   = cnt;
    reply_next = reply;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = cur;
    mem_wdata  = MARK_FREE;
    mem_raddr  = cur;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_next   = command;
          res_next   = '0;
          pend_next  = 1'b0;
          cnt_next   = '0;
          first_next = 1'b1;
          steps_next = '0;
          cur_next   = start_cluster[AW-1:0];
          unique case (command)
            CMD_FORMAT: begin
              addr_next  = '0;
              reply_next = 1'b1;
              state_next = ST_FORMAT;
            end
            CMD_ALLOC, CMD_COUNT: begin
              addr_next  = FDC_A;
              state_next = ST_SCAN;
            end
            CMD_FREE, CMD_APPEND: begin
              if (start_data) begin
                state_next = ST_WALK_RD;
              end else begin
                res_next.status = STAT_BAD_START;
                state_next      = ST_REPLY;
              end
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end
      end
      ST_FORMAT: begin
        mem_we    = 1'b1;
        mem_waddr = addr[AW-1:0];
        mem_wdata = layout_entry(LIMIT_W'(addr), FDC);
        addr_next = addr + 1'b1;
        if (addr == LAST) begin
          state_next = reply ? ST_REPLY : ST_IDLE;
          reply_next = 1'b0;
        end
      end
      ST_SCAN: begin
        mem_raddr = addr[AW-1:0];
        pidx_next = addr[AW-1:0];
        pend_next = scan_issue;
        if (scan_issue) begin
          addr_next = addr + 1'b1;
        end
        if (pend && (mem_rdata == MARK_FREE)) begin
          if (cmd == CMD_COUNT) begin
            cnt_next = cnt + 1'b1;
          end else begin
            // first free entry found, claim it as end of chain
            mem_we           = 1'b1;
            mem_waddr        = pidx;
            mem_wdata        = MARK_END;
            res_next.cluster = LINK_W'(pidx);
            pend_next        = 1'b0;
            state_next       = (cmd == CMD_APPEND) ? ST_WR_LINK : ST_REPLY;
          end
        end else if (!scan_issue && !pend) begin
          if (cmd == CMD_COUNT) begin
            res_next.free_clusters = cnt;
          end else begin
            res_next.status = STAT_NO_FREE;
          end
          state_next = ST_REPLY;
        end
      end
      ST_WALK_RD: begin
        mem_raddr  = cur;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        mem_raddr = mem_rdata[AW-1:0];
        if (cmd == CMD_FREE) begin
          if (first && !v_end && !v_link) begin
            res_next.status = STAT_BAD_START;
            state_next      = ST_REPLY;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = cur;
            mem_wdata  = MARK_FREE;
            first_next = 1'b0;
            if (v_link) begin
              cur_next = mem_rdata[AW-1:0];
            end else begin
              state_next = ST_REPLY;
            end
          end
        end else begin
          if (v_end) begin
            addr_next  = {1'b0, cur} + 1'b1;
            pend_next  = 1'b0;
            state_next = ST_SCAN;
          end else if (!v_link || (steps >= STEPS_MAX)) begin
            res_next.status = STAT_BAD_START;
            state_next      = ST_REPLY;
          end else begin
            cur_next   = mem_rdata[AW-1:0];
            steps_next = steps + 1'b1;
          end
        end
      end
      ST_WR_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = cur;
        mem_wdata  = res.cluster;
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // clearing pass rebuilds the layout after reset
      state <= ST_FORMAT;
      addr  <= '0;
      reply <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
      reply <= reply_next;
      pend  <= pend_next;
    end
    cmd   <= cmd_next;
    cur   <= cur_next;
    pidx  <= pidx_next;
    first <= first_next;
    steps <= steps_next;
    cnt   <= cnt_next;
    res   <= res_next;
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_pass_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !in_ready)
    else $error("item taken before clearing pass");

  a_count_only_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != STAT_OK)) |-> (res.free_clusters == '0))
    else $error("free count on failed item");

  a_cluster_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.cluster != '0)) |->
      (({1'b0, res.cluster} >= FDC) && (res.status == STAT_OK)))
    else $error("result cluster outside data area");

  a_reply_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result dropped before taken");

endmodule

>>> rtl/core/fat_cluster_chain_manager.sv
// FAT cluster chain manager: one command per item, one result per item. The link table sits
// in a single-port-write, single-port-read memory of TABLE_ENTRIES x 16 bits, and every
// command is paced by that memory, one entry per cycle. After reset the block rebuilds the
// formatted layout in a clearing pass during which in_ready stays low (cfg writes are
// taken). Format rewrites every entry of the table before it replies. Allocate and count scan
// from FIRST_DATA_CLUSTER up to min(cluster_limit, TABLE_ENTRIES); allocate stops early at
// the first free entry. Free reads the start entry and then frees each link of the chain in
// turn. Append walks the chain link by link, then scans from the chain's end upward and makes
// one more write. The result waits in an output register, and a new item is taken while it
// waits.
module fat_cluster_chain_manager #(
  parameter int TABLE_ENTRIES      = fccm_pkg::TABLE_ENTRIES_DEF,
  parameter int FIRST_DATA_CLUSTER = fccm_pkg::FIRST_DATA_CLUSTER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [fccm_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fccm_pkg::CMD_W-1:0]   command,
  input  logic [fccm_pkg::LINK_W-1:0]  start_cluster,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fccm_pkg::STAT_W-1:0]  status,
  output logic [fccm_pkg::LINK_W-1:0]  cluster,
  output logic [fccm_pkg::COUNT_W-1:0] free_clusters
);
  import fccm_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [LIMIT_W-1:0] ENTRIES = LIMIT_W'(TABLE_ENTRIES);

  logic [LIMIT_W-1:0] cluster_limit;
  logic [LIMIT_W-1:0] limit;
  logic               res_valid, res_ready;
  result_t            res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [LINK_W-1:0]  mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      cluster_limit <= cfg_wdata;
    end
  end

  // effective limit never exceeds the table
  assign limit = (cluster_limit > ENTRIES) ? ENTRIES : cluster_limit;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      status        <= res.status;
      cluster       <= res.cluster;
      free_clusters <= res.free_clusters;
    end
  end

  fccm_seq #(
    .TABLE_ENTRIES      (TABLE_ENTRIES),
    .FIRST_DATA_CLUSTER (FIRST_DATA_CLUSTER)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .limit         (limit),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .start_cluster (start_cluster),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  fccm_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
